[hdl/psmc_pkg.sv]
// psmc_pkg: shared types and constants of the plot segment mapper/clipper.
// No dependencies.
package psmc_pkg;

  localparam int unsigned MaxPointsDef = 256;
  localparam int signed   RowBottom    = 53;
  localparam int signed   RowTop       = 4;
  localparam int unsigned PlotWidth    = 120;
  localparam int unsigned ColOrigin    = 18;

  // configuration register indexes
  localparam logic [1:0] RegScaleMin  = 2'd0;
  localparam logic [1:0] RegScaleMax  = 2'd1;
  localparam logic [1:0] RegXDivs     = 2'd2;

  localparam logic KindSegment = 1'b0;
  localparam logic KindMarker  = 1'b1;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               marker;
    logic               last_sample;
  } in_req_t;

  typedef struct packed {
    logic        kind;
    logic [14:0] x_start;
    logic [5:0]  y_start;
    logic [14:0] x_end;
    logic [5:0]  y_end;
    logic        last_result;
  } out_req_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [15:0] data;
  } cfg_req_t;

  typedef enum logic [3:0] {
    StIdle,
    StColDiv,   // column = 18 + idx*120 / divs
    StRowDiv,   // row = 53 + (s-lo)*(-49) / span
    StClipA,    // start point clip divide
    StClipB,    // end point clip divide
    StEmitSeg,
    StEmitMark,
    StDone
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture request, start column divide
    logic start_row;  // start row divide
    logic start_a;    // start clip of start point
    logic start_b;    // start clip of end point
    logic commit;     // update prev state / index
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_done;
    logic first_pt;
    logic last_pt;
    logic mark;
    logic visible;
    logic clip_a;     // start point needs clipping
    logic clip_b;     // end point needs clipping
  } sts_t;

endpackage

[hdl/psmc_div.sv]
// psmc_div: signed restoring divider, one quotient bit per cycle, truncating.
// Depends on nothing but its ports.
module psmc_div #(
  parameter int unsigned NW = 40,
  parameter int unsigned DW = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [NW-1:0] num_i,
  input  logic signed [DW-1:0] den_i,
  output logic                 done_o,
  output logic signed [NW-1:0] quo_o
);
  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0] q_q, q_d;
  logic [DW-1:0] r_q, r_d;
  logic [DW-1:0] d_q, d_d;
  logic          neg_q, neg_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic [DW:0]   trial;
  logic [NW-1:0] an;

  always_comb begin
    an = num_i[NW-1] ? NW'(-num_i) : NW'(num_i);
    q_d = q_q; r_d = r_q; d_d = d_q; neg_d = neg_q;
    cnt_d = cnt_q; busy_d = busy_q;
    trial = {r_q, q_q[NW-1]} - {1'b0, d_q};
    if (start_i) begin
      q_d    = an;
      r_d    = '0;
      d_d    = den_i[DW-1] ? DW'(-den_i) : DW'(den_i);
      neg_d  = num_i[NW-1] ^ den_i[DW-1];
      cnt_d  = CW'(NW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[DW]) begin
        r_d = trial[DW-1:0];
        q_d = {q_q[NW-2:0], 1'b1};
      end else begin
        r_d = {r_q[DW-2:0], q_q[NW-1]};
        q_d = {q_q[NW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q   <= q_d;
    r_q   <= r_d;
    d_q   <= d_d;
    neg_q <= neg_d;
  end

  assign done_o = busy_q && (cnt_q == CW'(1));
  assign quo_o  = neg_q ? -$signed(q_d) : $signed(q_d);
endmodule

[hdl/psmc_datapath.sv]
// psmc_datapath: registers, mapping arithmetic and clipping for one point.
// Depends on psmc_pkg and psmc_div.
module psmc_datapath #(
  parameter int unsigned MaxPoints = psmc_pkg::MaxPointsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  psmc_pkg::cmd_t         cmd_i,
  input  psmc_pkg::in_req_t      in_req_i,
  input  logic                   cfg_we_i,
  input  psmc_pkg::cfg_req_t     cfg_i,
  output psmc_pkg::sts_t         sts_o,
  output logic [14:0]            col_o,
  output logic [5:0]             mark_row_o,
  output logic [14:0]            x0_o,
  output logic [5:0]             y0_o,
  output logic [14:0]            x1_o,
  output logic [5:0]             y1_o
);
  localparam int unsigned IW = $clog2(MaxPoints);

  // numerator / denominator widths of the shared divider
  localparam int unsigned NW = 40;
  localparam int unsigned DW = 24;

  logic signed [15:0] smin_q, smax_q;
  logic [7:0]         divs_q;
  logic [IW-1:0]      idx_q;
  logic [15:0]        pcol_q;
  logic signed [23:0] prow_q;
  logic signed [15:0] samp_q;
  logic               mark_q, last_q;
  logic [15:0]        col_q;
  logic signed [23:0] row_q;
  logic signed [23:0] x0_q, x1_q;
  logic signed [23:0] y0_q, y1_q;

  logic               div_start, div_done;
  logic signed [NW-1:0] div_num, div_quo;
  logic signed [DW-1:0] div_den;
  logic signed [23:0] span, xdiff, ydiff, tgt_a, tgt_b;
  logic signed [47:0] prod;
  logic [7:0]         divs_eff;

  assign divs_eff = (divs_q == 8'd0) ? 8'd1 : divs_q;
  assign span = ($signed({{8{smax_q[15]}}, smax_q}) - $signed({{8{smin_q[15]}}, smin_q}) < 1)
                ? 24'sd1 : ($signed({{8{smax_q[15]}}, smax_q}) - $signed({{8{smin_q[15]}}, smin_q}));

  assign ydiff = row_q - prow_q;
  assign xdiff = $signed({8'd0, col_q}) - $signed({8'd0, pcol_q});
  assign tgt_a = (prow_q < psmc_pkg::RowTop) ? 24'(psmc_pkg::RowTop) : 24'(psmc_pkg::RowBottom);
  assign tgt_b = (row_q  < psmc_pkg::RowTop) ? 24'(psmc_pkg::RowTop) : 24'(psmc_pkg::RowBottom);

  // one product per division feeding the divider numerator; registered by divider start
  always_comb begin
    prod = '0;
    div_den = 24'sd1;
    if (cmd_i.load) begin
      prod    = 48'(idx_q) * 48'(psmc_pkg::PlotWidth);
      div_den = $signed({16'd0, divs_eff});
    end else if (cmd_i.start_row) begin
      prod    = $signed({{8{samp_q[15]}}, samp_q} - {{8{smin_q[15]}}, smin_q}) *
                48'(psmc_pkg::RowTop - psmc_pkg::RowBottom);
      div_den = span;
    end else if (cmd_i.start_a) begin
      prod    = xdiff * (tgt_a - prow_q);
      div_den = ydiff;
    end else if (cmd_i.start_b) begin
      prod    = (x1_q - x0_q) * (tgt_b - y0_q);
      div_den = row_q - y0_q;
    end
  end
  assign div_num   = NW'(prod);
  assign div_start = cmd_i.load | cmd_i.start_row | cmd_i.start_a | cmd_i.start_b;

  psmc_div #(.NW(NW), .DW(DW)) u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_quo)
  );

  // which division the divider runs
  typedef enum logic [1:0] { OpCol, OpRow, OpA, OpB } op_e;
  op_e op_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smin_q <= '0;
      smax_q <= 16'sd1;
      divs_q <= 8'd6;
      idx_q  <= '0;
      pcol_q <= '0;
      prow_q <= '0;
      op_q   <= OpCol;
    end else begin
      if (cfg_we_i) begin
        case (cfg_i.index)
          psmc_pkg::RegScaleMin: smin_q <= cfg_i.data;
          psmc_pkg::RegScaleMax: smax_q <= cfg_i.data;
          psmc_pkg::RegXDivs:    divs_q <= cfg_i.data[7:0];
          default: ;
        endcase
      end
      if (cmd_i.load)      op_q <= OpCol;
      if (cmd_i.start_row) op_q <= OpRow;
      if (cmd_i.start_a)   op_q <= OpA;
      if (cmd_i.start_b)   op_q <= OpB;
      if (cmd_i.commit) begin
        pcol_q <= col_q;
        prow_q <= row_q;
        if (last_q) idx_q <= '0;
        else if (idx_q != IW'(MaxPoints - 1)) idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      samp_q <= in_req_i.sample;
      mark_q <= in_req_i.marker;
      last_q <= in_req_i.last_sample;
    end
    if (div_done) begin
      case (op_q)
        OpCol: col_q <= 16'(div_quo + NW'(psmc_pkg::ColOrigin));
        OpRow: begin
          row_q <= 24'(div_quo + NW'(psmc_pkg::RowBottom));
          // defaults for unclipped ends
          x0_q <= $signed({8'd0, pcol_q});
          y0_q <= prow_q;
          x1_q <= $signed({8'd0, col_q});
          y1_q <= 24'(div_quo + NW'(psmc_pkg::RowBottom));
        end
        OpA: begin
          x0_q <= $signed({8'd0, pcol_q}) + 24'(div_quo);
          y0_q <= tgt_a;
        end
        OpB: begin
          x1_q <= x0_q + 24'(div_quo);
          y1_q <= tgt_b;
        end
        default: ;
      endcase
    end
  end

  logic a_out, b_out;
  assign a_out = (prow_q < psmc_pkg::RowTop) || (prow_q > psmc_pkg::RowBottom);
  assign b_out = (row_q  < psmc_pkg::RowTop) || (row_q  > psmc_pkg::RowBottom);

  always_comb begin
    sts_o.div_done = div_done;
    sts_o.first_pt = (idx_q == '0);
    sts_o.last_pt  = last_q;
    sts_o.mark     = mark_q;
    sts_o.clip_a   = a_out;
    sts_o.clip_b   = b_out;
    if ((prow_q < psmc_pkg::RowTop && row_q < psmc_pkg::RowTop) ||
        (prow_q > psmc_pkg::RowBottom && row_q > psmc_pkg::RowBottom))
      sts_o.visible = 1'b0;
    else if (prow_q == row_q)
      sts_o.visible = !a_out;
    else
      sts_o.visible = 1'b1;
  end

  assign col_o = col_q[14:0];
  assign mark_row_o = (row_q < psmc_pkg::RowTop) ? 6'(psmc_pkg::RowTop) :
                      (row_q > psmc_pkg::RowBottom) ? 6'(psmc_pkg::RowBottom) : row_q[5:0];
  assign x0_o = x0_q[14:0];
  assign y0_o = y0_q[5:0];
  assign x1_o = x1_q[14:0];
  assign y1_o = y1_q[5:0];
endmodule

[hdl/psmc_ctrl.sv]
// psmc_ctrl: sequencer over the column, row and clip divisions and result emission.
// Depends on psmc_pkg.
module psmc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic             out_mark_o,
  output logic             out_last_o,
  input  psmc_pkg::sts_t   sts_i,
  output psmc_pkg::cmd_t   cmd_o
);
  psmc_pkg::state_e st_q, st_d;
  logic busy_q;   // divider run in flight for current state

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= psmc_pkg::StIdle;
      busy_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      busy_q <= (st_d == st_q) ? (busy_q | (cmd_o.start_row | cmd_o.start_a |
                                            cmd_o.start_b)) : 1'b0;
    end
  end

  always_comb begin
    st_d = st_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    out_mark_o = 1'b0;
    out_last_o = 1'b0;
    case (st_q)
      psmc_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          st_d = psmc_pkg::StColDiv;
        end
      end
      psmc_pkg::StColDiv: begin
        if (sts_i.div_done) st_d = psmc_pkg::StRowDiv;
      end
      psmc_pkg::StRowDiv: begin
        if (!busy_q) cmd_o.start_row = 1'b1;
        else if (sts_i.div_done) begin
          if (sts_i.first_pt) st_d = (sts_i.mark && !sts_i.last_pt) ?
                                     psmc_pkg::StEmitMark : psmc_pkg::StDone;
          else st_d = psmc_pkg::StClipA;
        end
      end
      psmc_pkg::StClipA: begin
        // new row is registered by now; visibility is decided here
        if (!sts_i.visible) st_d = sts_i.mark ? psmc_pkg::StEmitMark
                                              : psmc_pkg::StDone;
        else if (!sts_i.clip_a) st_d = psmc_pkg::StClipB;
        else if (!busy_q) cmd_o.start_a = 1'b1;
        else if (sts_i.div_done) st_d = psmc_pkg::StClipB;
      end
      psmc_pkg::StClipB: begin
        if (!sts_i.clip_b) st_d = psmc_pkg::StEmitSeg;
        else if (!busy_q) cmd_o.start_b = 1'b1;
        else if (sts_i.div_done) st_d = psmc_pkg::StEmitSeg;
      end
      psmc_pkg::StEmitSeg: begin
        out_valid_o = 1'b1;
        out_last_o  = !sts_i.mark;
        if (out_ready_i) st_d = sts_i.mark ? psmc_pkg::StEmitMark : psmc_pkg::StDone;
      end
      psmc_pkg::StEmitMark: begin
        out_valid_o = 1'b1;
        out_mark_o  = 1'b1;
        out_last_o  = 1'b1;
        if (out_ready_i) st_d = psmc_pkg::StDone;
      end
      psmc_pkg::StDone: begin
        cmd_o.commit = 1'b1;
        st_d = psmc_pkg::StIdle;
      end
      default: st_d = psmc_pkg::StIdle;
    endcase
  end
endmodule

[hdl/plot_segment_mapper_clipper.sv]
// plot_segment_mapper_clipper: top level of the polyline plotter with row clipping.
// Depends on psmc_pkg, psmc_ctrl, psmc_datapath, psmc_div.
//
// One point is processed at a time. A point is accepted, its column and then its row
// are divided out, then (after the first point of a plot) each segment end is checked
// for visibility and clipping and divided again if it needs clipping, each result
// request is emitted once the receiver takes it, and the point is committed. All
// divisions run on a single 40-bit restoring divider, one quotient bit per cycle,
// shared by the column map, row map and both clip interpolations. Results are emitted
// segment first, then marker; last_result flags the final request of each point.
module plot_segment_mapper_clipper #(
  parameter int unsigned MaxPoints = psmc_pkg::MaxPointsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  psmc_pkg::in_req_t   in_req_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output psmc_pkg::out_req_t  out_req_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  psmc_pkg::cfg_req_t  cfg_req_i
);
  psmc_pkg::cmd_t cmd;
  psmc_pkg::sts_t sts;
  logic        is_mark, is_last;
  logic [14:0] col, x0, x1;
  logic [5:0]  mrow, y0, y1;

  // the user must write config only while idle; the block does not enforce it
  assign cfg_ready_o = 1'b1;

  psmc_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o,
    .out_ready_i, .out_valid_o,
    .out_mark_o(is_mark), .out_last_o(is_last),
    .sts_i(sts), .cmd_o(cmd)
  );

  psmc_datapath #(.MaxPoints(MaxPoints)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i(cmd), .in_req_i,
    .cfg_we_i(cfg_valid_i), .cfg_i(cfg_req_i),
    .sts_o(sts), .col_o(col), .mark_row_o(mrow),
    .x0_o(x0), .y0_o(y0), .x1_o(x1), .y1_o(y1)
  );

  always_comb begin
    out_req_o.last_result = is_last;
    if (is_mark) begin
      out_req_o.kind    = psmc_pkg::KindMarker;
      out_req_o.x_start = col;
      out_req_o.y_start = mrow;
      out_req_o.x_end   = '0;
      out_req_o.y_end   = '0;
    end else begin
      out_req_o.kind    = psmc_pkg::KindSegment;
      out_req_o.x_start = x0;
      out_req_o.y_start = y0;
      out_req_o.x_end   = x1;
      out_req_o.y_end   = y1;
    end
  end

  // no new request taken while a result is pending
  a_no_in_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("input taken during output");

  // marker rows are always clamped and segment start rows clipped into the plot area
  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_req_o.y_start >= 6'd4 && out_req_o.y_start <= 6'd53))
    else $error("row out of range");

  // a marker is always the final result of its point
  a_mark_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_req_o.kind) |-> out_req_o.last_result)
    else $error("marker not last");
endmodule

[bench/tb.sv]
// tb: self-checking regression for plot_segment_mapper_clipper.
// Drives point requests and register writes and checks every result request against
// a local prediction of row map, column map and row clipping. Depends on psmc_pkg.
`timescale 1ns / 100ps
module tb;

  localparam int unsigned NumPoints = psmc_pkg::MaxPointsDef;
  localparam longint      CycleLimit = 2000000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  psmc_pkg::in_req_t  in_req = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  psmc_pkg::out_req_t out_req;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  psmc_pkg::cfg_req_t cfg_req = '0;

  // idle odds in percent for each side
  int unsigned send_idle = 0;
  int unsigned recv_stall = 0;

  // predictor copy of the registers and the plot state
  logic signed [15:0] lo_q = 16'sd0;
  logic signed [15:0] hi_q = 16'sd1;
  logic [7:0]         divs_q = 8'd6;
  int                 idx_q = 0;
  longint             prev_col_q = 0;
  longint             prev_row_q = 0;

  psmc_pkg::out_req_t pending_results[$];
  int          mismatches = 0;
  longint      cycles = 0;

  plot_segment_mapper_clipper dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_req_o   (out_req),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_req_i   (cfg_req)
  );

  always #5 clk = ~clk;

  // hard stop if the block hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("plot_segment_mapper_clipper regression: fail");
      $finish;
    end
  end

  // receiver side: random stall, changed at the falling edge
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall);
  end

  // result checker, sampled at the rising edge
  always @(posedge clk) begin
    psmc_pkg::out_req_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result request %h", out_req);
      end else begin
        want = pending_results.pop_front();
        if (want !== out_req) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected k%0d %0d,%0d -> %0d,%0d l%0d",
                      " got k%0d %0d,%0d -> %0d,%0d l%0d"},
                     want.kind, want.x_start, want.y_start, want.x_end, want.y_end,
                     want.last_result, out_req.kind, out_req.x_start, out_req.y_start,
                     out_req.x_end, out_req.y_end, out_req.last_result);
        end
      end
    end
  end

  function automatic longint row_of(logic signed [15:0] s);
    longint span;
    span = longint'(hi_q) - longint'(lo_q);
    if (span < 1) span = 1;
    // SystemVerilog division truncates toward zero, as required
    return ((longint'(s) - longint'(lo_q)) * (psmc_pkg::RowTop - psmc_pkg::RowBottom))
           / span + psmc_pkg::RowBottom;
  endfunction

  function automatic longint col_of(int idx);
    longint d;
    d = (divs_q == 0) ? 1 : divs_q;
    return (psmc_pkg::ColOrigin + (longint'(idx) * psmc_pkg::PlotWidth) / d) & 64'hFFFF;
  endfunction

  function automatic longint x_shift(longint xa, longint xb, longint ya, longint yb,
                                     longint tgt);
    if (yb == ya) return 0;
    return (xb - xa) * (tgt - ya) / (yb - ya);
  endfunction

  function automatic longint clamp_row(longint r);
    return (r < psmc_pkg::RowTop) ? psmc_pkg::RowTop :
           ((r > psmc_pkg::RowBottom) ? psmc_pkg::RowBottom : r);
  endfunction

  // expected result requests of one point, and advance of the plot state
  task automatic predict_point(psmc_pkg::in_req_t p);
    longint   row, col, x0, y0, x1, y1;
    bit       vis;
    psmc_pkg::out_req_t r;
    psmc_pkg::out_req_t got[$];
    row = row_of(p.sample);
    col = col_of(idx_q);
    if (idx_q == 0) begin
      if (!p.last_sample && p.marker) begin
        r = '0; r.kind = psmc_pkg::KindMarker; r.x_start = col[14:0];
        r.y_start = 6'(clamp_row(row)); got.push_back(r);
      end
    end else begin
      x0 = prev_col_q; y0 = prev_row_q; x1 = col; y1 = row;
      if ((y0 < psmc_pkg::RowTop && y1 < psmc_pkg::RowTop) ||
          (y0 > psmc_pkg::RowBottom && y1 > psmc_pkg::RowBottom)) vis = 0;
      else if (y0 == y1) vis = (y0 >= psmc_pkg::RowTop && y0 <= psmc_pkg::RowBottom);
      else begin
        vis = 1;
        if (y0 < psmc_pkg::RowTop) begin
          x0 += x_shift(x0, x1, y0, y1, psmc_pkg::RowTop); y0 = psmc_pkg::RowTop;
        end else if (y0 > psmc_pkg::RowBottom) begin
          x0 += x_shift(x0, x1, y0, y1, psmc_pkg::RowBottom); y0 = psmc_pkg::RowBottom;
        end
        if (y1 < psmc_pkg::RowTop) begin
          x1 = x0 + x_shift(x0, x1, y0, y1, psmc_pkg::RowTop); y1 = psmc_pkg::RowTop;
        end else if (y1 > psmc_pkg::RowBottom) begin
          x1 = x0 + x_shift(x0, x1, y0, y1, psmc_pkg::RowBottom);
          y1 = psmc_pkg::RowBottom;
        end
      end
      if (vis) begin
        r = '0; r.kind = psmc_pkg::KindSegment; r.x_start = x0[14:0]; r.y_start = y0[5:0];
        r.x_end = x1[14:0]; r.y_end = y1[5:0]; got.push_back(r);
      end
      if (p.marker) begin
        r = '0; r.kind = psmc_pkg::KindMarker; r.x_start = col[14:0];
        r.y_start = 6'(clamp_row(row)); got.push_back(r);
      end
    end
    if (got.size() > 0) got[got.size()-1].last_result = 1'b1;
    foreach (got[i]) pending_results.push_back(got[i]);
    prev_col_q = col;
    prev_row_q = row;
    if (p.last_sample) idx_q = 0;
    else if (idx_q < NumPoints - 1) idx_q++;
  endtask

  // send one point request; prediction is taken at acceptance
  task automatic send_point(logic signed [15:0] s, logic mk, logic lst);
    do @(negedge clk); while ($urandom_range(99) < send_idle);
    in_valid <= 1'b1;
    in_req <= '{sample: s, marker: mk, last_sample: lst};
    do @(posedge clk); while (!in_ready);
    predict_point('{sample: s, marker: mk, last_sample: lst});
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // wait for all results, then let the block go idle
  task automatic drain;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_req <= '{index: idx, data: val};
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      psmc_pkg::RegScaleMin: lo_q = val;
      psmc_pkg::RegScaleMax: hi_q = val;
      psmc_pkg::RegXDivs:    divs_q = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // close any open plot so every phase starts at point zero
  task automatic end_plot;
    send_point(16'sd0, 1'b0, 1'b1);
  endtask

  task automatic test_reset_defaults;
    send_point(16'sd0, 1'b1, 1'b0);
    send_point(16'sd1, 1'b1, 1'b0);
    send_point(-16'sd1, 1'b0, 1'b1);
    send_point(16'sd5, 1'b1, 1'b1);       // one-point plot: nothing
  endtask

  task automatic test_extremes;
    write_reg(psmc_pkg::RegScaleMin, 16'h8000);
    write_reg(psmc_pkg::RegScaleMax, 16'h7FFF);
    write_reg(psmc_pkg::RegXDivs, 16'd1);
    send_point(16'sh8000, 1'b1, 1'b0);
    send_point(16'sh7FFF, 1'b1, 1'b0);
    send_point(16'sh7FFF, 1'b0, 1'b0);    // flat, visible
    send_point(16'sh8000, 1'b1, 1'b1);
    // empty span and zero divisions
    write_reg(psmc_pkg::RegScaleMin, 16'sd100);
    write_reg(psmc_pkg::RegScaleMax, 16'sd100);
    write_reg(psmc_pkg::RegXDivs, 16'd0);
    send_point(16'sd100, 1'b0, 1'b0);
    send_point(16'sd99, 1'b1, 1'b0);      // row below bottom: clip
    send_point(16'sd98, 1'b0, 1'b0);      // both below: invisible
    send_point(16'sd102, 1'b1, 1'b0);     // crosses both bounds
    send_point(16'sd200, 1'b1, 1'b0);     // both above
    send_point(16'sd50, 1'b0, 1'b1);
    // a long plot saturates the point index
    write_reg(psmc_pkg::RegXDivs, 16'd255);
    write_reg(psmc_pkg::RegScaleMin, -16'sd10);
    write_reg(psmc_pkg::RegScaleMax, 16'sd10);
    for (int i = 0; i < 260; i++) send_point(16'($signed($urandom_range(30)) - 15),
                                             1'($urandom_range(1)), 1'b0);
    end_plot();
  endtask

  task automatic test_random(int n);
    int k;
    logic signed [15:0] s;
    k = 0;
    while (k < n) begin
      // new scale: half the time -1000..1000, else a narrow window or random (maybe inverted) bounds
      case ($urandom_range(3))
        0: begin
             write_reg(psmc_pkg::RegScaleMin, 16'($urandom));
             write_reg(psmc_pkg::RegScaleMax, 16'($urandom));
           end
        1: begin
             s = 16'($urandom);
             write_reg(psmc_pkg::RegScaleMin, s);
             write_reg(psmc_pkg::RegScaleMax, 16'(s + $urandom_range(1, 200)));
           end
        default: begin
             write_reg(psmc_pkg::RegScaleMin, -16'sd1000);
             write_reg(psmc_pkg::RegScaleMax, 16'sd1000);
           end
      endcase
      write_reg(psmc_pkg::RegXDivs, ($urandom_range(3) == 0) ? 16'($urandom_range(255))
                                                           : 16'($urandom_range(1, 12)));
      repeat ($urandom_range(20, 60)) begin
        if ($urandom_range(9) == 0) s = 16'($urandom);
        else s = 16'($signed($urandom_range(2400)) - 1200);
        send_point(s, 1'($urandom_range(3) == 0), 1'($urandom_range(15) == 0));
        k++;
      end
      end_plot();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_extremes();
    send_idle = 9;  recv_stall = 51;
    test_random(500);
    send_idle = 51; recv_stall = 9;
    test_random(500);
    send_idle = 0;  recv_stall = 0;
    test_random(500);
    drain();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("plot_segment_mapper_clipper regression: pass");
    end else begin
      $display("plot_segment_mapper_clipper regression: fail");
    end
    $finish;
  end

endmodule
